[hw/rtl/dpm_pkg.sv]
package dpm_pkg;

    localparam int VTX_W    = 6;
    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 7;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [VTX_W-1:0]    row;
        logic [VTX_W-1:0]    col;
        logic [WEIGHT_W-1:0] weight;
    } in_beat_t;

    typedef struct packed {
        logic [VTX_W-1:0]    vertex;
        logic [VTX_W-1:0]    parent;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                disconnected;
        logic                last;
    } out_beat_t;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic             init;
        logic             shift;
        logic             apply;
        logic             search;
        logic             mark;
        logic [VTX_W-1:0] mark_idx;
        logic [VTX_W-1:0] parent;
    } cell_ctrl_t;

    // running minimum passed along the chain
    typedef struct packed {
        logic                found;
        logic [WEIGHT_W-1:0] key;
        logic [VTX_W-1:0]    vtx;
        logic [VTX_W-1:0]    par;
    } search_tok_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_READ,
        ST_DRAIN,
        ST_APPLY,
        ST_SEARCH,
        ST_EMIT
    } state_t;

endpackage

[hw/rtl/dense_prim_mst.sv]
// dense_prim_mst: Prim minimum spanning tree over a dense weight matrix
// input channel (in_valid/in_stall/in_data): a beat with cmd write stores one
// matrix entry (weight 0 = no edge); a beat with cmd run
// grows a tree from vertex 0 over the first vertex_count vertices
// cfg_we/cfg_wdata set vertex_count (clamped to 2..MAX_VERTICES) while idle
// output channel (out_valid/out_stall/out_data): one beat per tree edge, last
// set on the final one; a single disconnected beat ends a run early
// a run first initialises the cells; each round then streams the row of the
// vertex chosen last out of the matrix memory into the cells (one memory
// read per cycle), relaxes the keys, runs the minimum search along the cell
// row and emits one edge
// in_stall stays high from run acceptance until the last beat is loaded
// a stalled receiver holds the emit step; the output register frees the
// input side once the last beat is loaded
// reset clears control state and sets vertex_count to 64; matrix contents
// are undefined until written
module dense_prim_mst #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dpm_pkg::COUNT_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  dpm_pkg::in_beat_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output dpm_pkg::out_beat_t           out_data
);
    import dpm_pkg::*;

    localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int ADDR_W = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam logic [IDX_W-1:0]   CNT_LAST  = IDX_W'(MAX_VERTICES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_VERTICES);
    localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(2);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [VTX_W-1:0]    u_reg, u_next;
    logic [COUNT_W-1:0]  round_reg, round_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [COUNT_W-1:0]  cfg_count_reg;
    logic                rd_valid_reg;
    logic                out_valid_reg, out_valid_next;
    out_beat_t           out_data_reg, out_data_next;
    logic [WEIGHT_W-1:0] rd_data_reg;

    logic [WEIGHT_W-1:0] mem [MAX_VERTICES * MAX_VERTICES];

    cell_ctrl_t          ctrl;
    search_tok_t         best;
    logic                in_acc;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [COUNT_W-1:0]  eff_count;
    logic                load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // vertex count clamp
    always_comb
    begin
        priority if (cfg_count_reg < COUNT_MIN)
            eff_count = COUNT_MIN;
        else if (cfg_count_reg > COUNT_MAX)
            eff_count = COUNT_MAX;
        else
            eff_count = cfg_count_reg;
    end

    // matrix addressing, column fed from the top index downward
    assign wr_en   = in_acc && (in_data.cmd == CMD_WRITE)
                     && (COUNT_W'(in_data.row) < COUNT_MAX)
                     && (COUNT_W'(in_data.col) < COUNT_MAX);
    assign wr_addr = ADDR_W'(in_data.row) * ADDR_W'(MAX_VERTICES)
                     + ADDR_W'(in_data.col);
    assign rd_addr = ADDR_W'(u_reg) * ADDR_W'(MAX_VERTICES)
                     + ADDR_W'(CNT_LAST - cnt_reg);

    // weight matrix memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_data.weight;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count_reg <= COUNT_W'(64);
        end
        else if (cfg_we)
        begin
            cfg_count_reg <= cfg_wdata;
        end
    end

    dpm_chain #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .count   (n_reg),
        .w_in    (rd_data_reg),
        .tok_out (best)
    );

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            u_reg         <= '0;
            round_reg     <= '0;
            n_reg         <= COUNT_MAX;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            u_reg         <= u_next;
            round_reg     <= round_next;
            n_reg         <= n_next;
            rd_valid_reg  <= (state_reg == ST_READ);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // next state and cell controls
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        u_next         = u_reg;
        round_next     = round_reg;
        n_next         = n_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        load           = 1'b0;
        ctrl           = '0;
        ctrl.shift     = rd_valid_reg;
        ctrl.parent    = u_reg;
        ctrl.mark_idx  = best.vtx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.cmd == CMD_RUN))
                begin
                    n_next     = eff_count;
                    u_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                ctrl.init  = 1'b1;
                round_next = COUNT_W'(1);
                cnt_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                ctrl.apply = 1'b1;
                cnt_next   = '0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                ctrl.search = 1'b1;
                cnt_next    = cnt_reg + IDX_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                load = !out_valid_reg || !out_stall;
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (!best.found)
                    begin
                        out_data_next              = '0;
                        out_data_next.disconnected = 1'b1;
                        out_data_next.last         = 1'b1;
                        state_next                 = ST_IDLE;
                    end
                    else
                    begin
                        out_data_next.vertex       = best.vtx;
                        out_data_next.parent       = best.par;
                        out_data_next.edge_weight  = best.key;
                        out_data_next.disconnected = 1'b0;
                        out_data_next.last         = (round_reg == n_reg - COUNT_W'(1));
                        ctrl.mark                  = 1'b1;
                        u_next                     = best.vtx;
                        round_next                 = round_reg + COUNT_W'(1);
                        cnt_next                   = '0;
                        state_next = out_data_next.last ? ST_IDLE : ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // a disconnected beat always closes the run
    a_disc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.disconnected |-> out_data.last)
        else $error("disconnected beat without last");

    // an accepted run command starts the tree setup
    a_run_init: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_data.cmd == CMD_RUN) |=> state_reg == ST_INIT)
        else $error("run command did not start setup");

    // weights shift only right after a matrix read
    a_shift_src: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_READ))
        else $error("weight shift without a read");
`endif

endmodule

[hw/rtl/dpm_cell.sv]
module dpm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dpm_pkg::cell_ctrl_t           ctrl,
    input  logic                          active,
    input  logic [dpm_pkg::WEIGHT_W-1:0]  w_in,
    output logic [dpm_pkg::WEIGHT_W-1:0]  w_out,
    input  dpm_pkg::search_tok_t          tok_in,
    output dpm_pkg::search_tok_t          tok_out
);
    import dpm_pkg::*;

    localparam logic [VTX_W-1:0] MY_IDX = VTX_W'(CELL_IDX);

    logic                in_tree_reg;
    logic                key_valid_reg;
    logic [WEIGHT_W-1:0] key_reg;
    logic [VTX_W-1:0]    par_reg;
    logic [WEIGHT_W-1:0] w_reg;
    search_tok_t         tok_reg;

    logic        relax_hit;
    logic        beats_in;
    search_tok_t self_tok;

    // candidate decisions
    assign relax_hit = active && (w_reg != '0) && !in_tree_reg
                       && (!key_valid_reg || (w_reg < key_reg));
    assign beats_in  = active && !in_tree_reg && key_valid_reg
                       && (!tok_in.found || (key_reg < tok_in.key));

    always_comb
    begin
        self_tok.found = 1'b1;
        self_tok.key   = key_reg;
        self_tok.vtx   = MY_IDX;
        self_tok.par   = par_reg;
    end

    // per-vertex tree state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg   <= 1'b0;
            key_valid_reg <= 1'b0;
            key_reg       <= '0;
            par_reg       <= '0;
        end
        else if (ctrl.init)
        begin
            in_tree_reg   <= (CELL_IDX == 0);
            key_valid_reg <= (CELL_IDX == 0);
            key_reg       <= '0;
            par_reg       <= '0;
        end
        else
        begin
            if (ctrl.mark && (ctrl.mark_idx == MY_IDX))
            begin
                in_tree_reg <= 1'b1;
            end
            if (ctrl.apply && relax_hit)
            begin
                key_reg       <= w_reg;
                key_valid_reg <= 1'b1;
                par_reg       <= ctrl.parent;
            end
        end
    end

    // weight shift line and search stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= '0;
            tok_reg <= '0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                w_reg <= w_in;
            end
            if (ctrl.search)
            begin
                tok_reg <= beats_in ? self_tok : tok_in;
            end
        end
    end

    assign w_out   = w_reg;
    assign tok_out = tok_reg;

endmodule

[hw/rtl/dpm_chain.sv]
module dpm_chain #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dpm_pkg::cell_ctrl_t           ctrl,
    input  logic [dpm_pkg::COUNT_W-1:0]   count,
    input  logic [dpm_pkg::WEIGHT_W-1:0]  w_in,
    output dpm_pkg::search_tok_t          tok_out
);
    import dpm_pkg::*;

    logic [WEIGHT_W-1:0] w_link   [MAX_VERTICES];
    search_tok_t         tok_link [MAX_VERTICES];

    // row of cells, weights enter at cell 0, search runs toward the top
    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        logic [WEIGHT_W-1:0] w_src;
        search_tok_t         tok_src;
        logic                act;

        if (i == 0)
        begin : g_head
            assign w_src   = w_in;
            assign tok_src = '0;
        end
        else
        begin : g_body
            assign w_src   = w_link[i-1];
            assign tok_src = tok_link[i-1];
        end

        assign act = (COUNT_W'(i) < count);

        dpm_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .active  (act),
            .w_in    (w_src),
            .w_out   (w_link[i]),
            .tok_in  (tok_src),
            .tok_out (tok_link[i])
        );
    end

    assign tok_out = tok_link[MAX_VERTICES-1];

endmodule

[sim/tb_dense_prim_mst.sv]
`timescale 1ns / 1ps

module tb_dense_prim_mst;
    import dpm_pkg::*;

    localparam int NV        = 64;
    localparam int SETTLE    = 300;
    localparam int STALL_RUN = 600;
    localparam int WATCHDOG  = 8000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    in_beat_t            in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_beat_t           out_data;

    // pending input beats and expected tree edges
    in_beat_t            beat_q[$];
    out_beat_t           edge_q[$];

    // predictor state
    logic [WEIGHT_W-1:0] mat[NV*NV];
    bit                  written[NV*NV];
    logic [WEIGHT_W-1:0] key_w[NV];
    bit                  key_ok[NV];
    bit                  in_tree[NV];
    logic [VTX_W-1:0]    par_v[NV];
    logic [COUNT_W-1:0]  vtx_count = 7'd64;

    int                  mismatches = 0;
    int                  idle_cycles = 0;
    bit                  quiet = 1'b0;
    bit                  hold_go = 1'b0;
    int                  hold_left = 0;
    int                  n_items = 0;

    dense_prim_mst dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // lower the keys of every neighbour of u outside the tree
    function automatic void relax_row(int u, int n);
        logic [WEIGHT_W-1:0] c;
        for (int v = 0; v < n; v++)
        begin
            c = mat[u*NV + v];
            if (c != 0 && !in_tree[v] && (!key_ok[v] || c < key_w[v]))
            begin
                key_w[v]  = c;
                key_ok[v] = 1'b1;
                par_v[v]  = u[VTX_W-1:0];
            end
        end
    endfunction

    // grow the spanning tree from vertex 0 and queue its edges
    function automatic void grow_tree();
        int                  n;
        int                  pick;
        logic [WEIGHT_W-1:0] low;
        out_beat_t           e;
        n = vtx_count < 2 ? 2 : (vtx_count > NV ? NV : int'(vtx_count));
        for (int v = 0; v < NV; v++)
        begin
            key_w[v] = '0; key_ok[v] = 0; in_tree[v] = 0; par_v[v] = '0;
        end
        in_tree[0] = 1'b1;
        key_ok[0]  = 1'b1;
        relax_row(0, n);
        for (int r = 1; r < n; r++)
        begin
            pick = -1;
            low  = '0;
            for (int v = 0; v < n; v++)
                if (!in_tree[v] && key_ok[v] && (pick < 0 || key_w[v] < low))
                begin
                    pick = v;
                    low  = key_w[v];
                end
            e = '0;
            if (pick < 0)
            begin
                e.disconnected = 1'b1;
                e.last         = 1'b1;
                edge_q.push_back(e);
                return;
            end
            in_tree[pick] = 1'b1;
            e.vertex      = pick[VTX_W-1:0];
            e.parent      = par_v[pick];
            e.edge_weight = key_w[pick];
            e.last        = (r == n - 1);
            edge_q.push_back(e);
            relax_row(pick, n);
        end
    endfunction

    // input driver: predicts each accepted beat, then loads the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (in_data.cmd == CMD_WRITE)
                    mat[{in_data.row, in_data.col}] = in_data.weight;
                else
                    grow_tree();
            end
            if (!in_valid || !in_stall)
            begin
                if (beat_q.size() > 0 && (quiet || $urandom_range(99) >= 7))
                begin
                    in_data  <= beat_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (edge_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected edge beat v=%0d p=%0d w=%0d d=%0d l=%0d",
                                 out_data.vertex, out_data.parent, out_data.edge_weight,
                                 out_data.disconnected, out_data.last);
                end
                else if (out_data !== edge_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("edge mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 edge_q[0].vertex, edge_q[0].parent, edge_q[0].edge_weight,
                                 edge_q[0].disconnected, edge_q[0].last,
                                 out_data.vertex, out_data.parent, out_data.edge_weight,
                                 out_data.disconnected, out_data.last);
                    void'(edge_q.pop_front());
                end
                else
                    void'(edge_q.pop_front());
            end
            if (hold_go)
                hold_left <= STALL_RUN;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
            out_stall <= hold_go || hold_left > 1 || (!quiet && $urandom_range(99) < 7);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("dense_prim_mst test failed");
            $finish;
        end
    end

    task automatic put_entry(int r, int c, int w);
        in_beat_t b;
        b        = '0;
        b.cmd    = CMD_WRITE;
        b.row    = r[VTX_W-1:0];
        b.col    = c[VTX_W-1:0];
        b.weight = w[WEIGHT_W-1:0];
        written[r*NV + c] = 1'b1;
        beat_q.push_back(b);
        n_items++;
    endtask

    task automatic put_run();
        in_beat_t b;
        b        = '0;
        b.cmd    = CMD_RUN;
        b.row    = VTX_W'($urandom);
        b.col    = VTX_W'($urandom);
        b.weight = WEIGHT_W'($urandom);
        beat_q.push_back(b);
        n_items++;
    endtask

    // fill every entry of the n x n corner not written yet: no edge one time in four, else a random weight
    task automatic cover_corner(int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!written[r*NV + c])
                    put_entry(r, c, ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 65535));
    endtask

    task automatic drain();
        while (beat_q.size() > 0 || in_valid || edge_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[COUNT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        vtx_count = v[COUNT_W-1:0];
    endtask

    initial
    begin
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, tie, self loop, directed edge
        set_count(4);
        put_entry(0, 1, 65535);
        put_entry(0, 2, 5);
        put_entry(0, 3, 5);
        put_entry(1, 1, 7);
        put_entry(2, 1, 3);
        put_entry(1, 0, 1);
        put_entry(63, 63, 65535);
        put_entry(63, 0, 1);
        cover_corner(4);
        put_run();
        drain();

        // count below range acts as two, root with no edge is disconnected
        set_count(0);
        put_entry(0, 1, 0);
        put_run();
        drain();
        set_count(2);
        put_entry(0, 1, 65535);
        put_run();
        drain();

        // full size: count above range acts as 64, only rows 0 and 63 walked
        set_count(127);
        for (int c = 0; c < NV; c++)
        begin
            put_entry(0, c, (c == NV - 1) ? 40000 : 0);
            put_entry(NV - 1, c, (c == 0) ? 1 : 0);
        end
        put_run();
        drain();
        set_count(64);
        put_run();
        drain();

        // small graph, receiver holds off while writes queue behind the run
        set_count(8);
        cover_corner(8);
        for (int c = 1; c < 8; c++)
            put_entry(0, c, $urandom_range(1, 65535));
        drain();
        put_run();
        for (int i = 0; i < 10; i++)
            put_entry($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535));
        while (beat_q.size() > 10)
            @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        drain();

        // random phases on small graphs
        for (int p = 0; p < 7; p++)
        begin
            quiet = (p >= 2 && p < 4);
            n = $urandom_range(2, 8);
            if (n == 2 && $urandom_range(1))
                set_count($urandom_range(0, 1));
            else
                set_count(n);
            for (int i = $urandom_range(3, 12); i > 0; i--)
            begin
                if ($urandom_range(4) == 0)
                    put_entry($urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 65535));
                else
                    put_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              $urandom_range(3) == 0 ? 0 :
                              ($urandom_range(1) ? $urandom_range(1, 4)
                                                 : $urandom_range(1, 65535)));
            end
            put_run();
            if ($urandom_range(1))
                put_run();
            drain();
        end
        quiet = 1'b0;

        if (mismatches == 0)
            $display("dense_prim_mst test passed");
        else
            $display("dense_prim_mst test failed");
        $finish;
    end

endmodule
